// ===== rtl/rdc_pkg.sv =====
package rdc_pkg;

	localparam int INT_BITS_DEF   = 32;
	localparam int FRAC_BITS_DEF  = 32;
	localparam int MAX_DIGITS_DEF = 64;

	localparam int FIELD_W     = 32;
	localparam int RADIX_W     = 6;
	localparam int LIMIT_W     = 7;
	localparam int DIGIT_W     = 6;
	localparam int CHAR_W      = 7;
	localparam int CNT_W       = 7;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 7;

	localparam logic [CFG_INDEX_W-1:0] REG_RADIX       = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_DIGIT_LIMIT = 2'd1;

	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd2;
	localparam logic [LIMIT_W-1:0] LIMIT_MIN   = 7'd1;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd16;

	localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'h30;
	localparam logic [CHAR_W-1:0]  ASCII_A    = 7'h41;
	localparam logic [DIGIT_W-1:0] DEC_DIGITS = 6'd10;

	typedef struct packed {
		logic [FIELD_W-1:0] integer_part;
		logic [FIELD_W-1:0] fraction_part;
	} item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] digit_char;
		logic              is_fraction;
		logic [CNT_W-1:0]  fraction_count;
		logic              last;
	} digit_t;

	function automatic logic [CHAR_W-1:0] digit_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] dx;
		dx = CHAR_W'(d);
		if (d >= DEC_DIGITS) begin
			digit_ascii = dx - CHAR_W'(DEC_DIGITS) + ASCII_A;
		end else begin
			digit_ascii = dx + ASCII_ZERO;
		end
	endfunction

endpackage

// ===== rtl/rdc_store.sv =====
module rdc_store #(
	parameter int DEPTH = rdc_pkg::MAX_DIGITS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [rdc_pkg::DIGIT_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [rdc_pkg::DIGIT_W-1:0] rdata
);
	import rdc_pkg::*;

	logic [DIGIT_W-1:0] mem_q [DEPTH];
	logic [DIGIT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/radix_digit_converter.sv =====
// Channel  Direction  Handshake                 Payload
// item     in         item_valid / item_stall   rdc_pkg::item_t  (integer_part, fraction_part)
// digit    out        digit_valid / digit_stall rdc_pkg::digit_t (one ASCII digit per request)
// cfg      in         cfg_valid / cfg_ready     cfg_index, cfg_data (0 radix, 1 digit_limit)
//
// Integer digits come from the bit-serial divider by the radix; a zero integer part gives a single 0 digit.
// Each fraction digit comes from the radix multiplier in ST_FRAC; a final ST_FRAC step ends the fraction.
// Each emitted digit is read from the registered digit store (ST_EMIT_RD, then ST_EMIT_OUT), plus stalls.
// One item at a time: item_stall is high from acceptance until its last digit is taken.
// arst_n clears the sequencer and loads radix 2 and digit limit 16; cfg_ready is always high.
module radix_digit_converter #(
	parameter int INT_BITS   = rdc_pkg::INT_BITS_DEF,
	parameter int FRAC_BITS  = rdc_pkg::FRAC_BITS_DEF,
	parameter int MAX_DIGITS = rdc_pkg::MAX_DIGITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            item_valid,
	output logic                            item_stall,
	input  rdc_pkg::item_t                  item,
	output logic                            digit_valid,
	input  logic                            digit_stall,
	output rdc_pkg::digit_t                 digit,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rdc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rdc_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import rdc_pkg::*;

	localparam int DEPTH = (INT_BITS > MAX_DIGITS) ? INT_BITS : MAX_DIGITS;
	localparam int AW    = $clog2(DEPTH);
	localparam int BW    = $clog2(INT_BITS);
	localparam int PW    = FRAC_BITS + RADIX_W;

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_INT_CHK  = 6'b000010,
		ST_DIV      = 6'b000100,
		ST_FRAC     = 6'b001000,
		ST_EMIT_RD  = 6'b010000,
		ST_EMIT_OUT = 6'b100000
	} state_t;

	state_t state_q;

	logic [RADIX_W-1:0]   radix_q;
	logic [LIMIT_W-1:0]   digit_limit_q;
	logic [INT_BITS-1:0]  quot_q;
	logic [FRAC_BITS-1:0] frac_q;
	logic [DIGIT_W-1:0]   rem_q;
	logic [BW-1:0]        bit_q;
	logic [CNT_W-1:0]     int_cnt_q;
	logic [CNT_W-1:0]     frac_cnt_q;
	logic [CNT_W-1:0]     keep_q;
	logic [CNT_W-1:0]     emit_q;
	logic                 is_frac_q;
	logic                 last_q;

	logic [RADIX_W-1:0]   radix_c;
	logic [LIMIT_W-1:0]   limit_c;
	logic [CNT_W-1:0]     budget;
	logic [CNT_W-1:0]     total;
	logic [FIELD_W+INT_BITS-1:0]  int_ext;
	logic [FIELD_W+FRAC_BITS-1:0] frac_ext;
	logic [DIGIT_W:0]     rem_sh;
	logic                 rem_ge;
	logic [DIGIT_W:0]     rem_nx;
	logic [INT_BITS-1:0]  quot_nx;
	logic [PW-1:0]        prod;
	logic [DIGIT_W-1:0]   frac_digit;
	logic                 div_done;
	logic                 frac_done;
	logic                 item_take;
	logic                 digit_take;
	logic [CNT_W-1:0]     emit_addr;

	logic                 st_we;
	logic [AW-1:0]        st_waddr;
	logic [DIGIT_W-1:0]   st_wdata;
	logic                 st_re;
	logic [DIGIT_W-1:0]   st_rdata;

	assign cfg_ready  = 1'b1;
	assign item_stall = (state_q != ST_IDLE);
	assign item_take  = item_valid && !item_stall;
	assign digit_valid = (state_q == ST_EMIT_OUT);
	assign digit_take  = digit_valid && !digit_stall;

	always_comb begin
		priority if (radix_q < RADIX_MIN) begin
			radix_c = RADIX_MIN;
		end else if (radix_q > RADIX_MAX) begin
			radix_c = RADIX_MAX;
		end else begin
			radix_c = radix_q;
		end
		priority if (digit_limit_q < LIMIT_MIN) begin
			limit_c = LIMIT_MIN;
		end else if (digit_limit_q > LIMIT_W'(MAX_DIGITS)) begin
			limit_c = LIMIT_W'(MAX_DIGITS);
		end else begin
			limit_c = digit_limit_q;
		end
	end

	assign budget = (CNT_W'(limit_c) > int_cnt_q) ? CNT_W'(limit_c) - int_cnt_q : '0;
	assign total  = int_cnt_q + keep_q;

	assign int_ext  = {{INT_BITS{1'b0}}, item.integer_part};
	assign frac_ext = {{FRAC_BITS{1'b0}}, item.fraction_part};

	assign rem_sh   = {rem_q, quot_q[INT_BITS-1]};
	assign rem_ge   = rem_sh >= {1'b0, radix_c};
	assign rem_nx   = rem_ge ? rem_sh - {1'b0, radix_c} : rem_sh;
	assign quot_nx  = {quot_q[INT_BITS-2:0], rem_ge};
	assign div_done = (bit_q == BW'(INT_BITS - 1));

	assign prod       = PW'(frac_q) * PW'(radix_c);
	assign frac_digit = prod[FRAC_BITS +: DIGIT_W];
	assign frac_done  = (frac_cnt_q == budget) || (frac_q == '0);

	assign emit_addr = (emit_q < int_cnt_q) ? int_cnt_q - CNT_W'(1) - emit_q : emit_q;

	always_comb begin
		st_we    = 1'b0;
		st_waddr = '0;
		st_wdata = '0;
		unique case (state_q)
			ST_INT_CHK: begin
				st_we = (quot_q == '0) && (int_cnt_q == '0);
			end
			ST_DIV: begin
				st_we    = div_done;
				st_waddr = int_cnt_q[AW-1:0];
				st_wdata = rem_nx[DIGIT_W-1:0];
			end
			ST_FRAC: begin
				st_we    = !frac_done;
				st_waddr = AW'(int_cnt_q + frac_cnt_q);
				st_wdata = frac_digit;
			end
			default: begin
			end
		endcase
	end

	assign st_re = (state_q == ST_EMIT_RD);

	rdc_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (emit_addr[AW-1:0]),
		.rdata (st_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q       <= RADIX_RESET;
			digit_limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_RADIX) begin
				radix_q <= cfg_data[RADIX_W-1:0];
			end else if (cfg_index == REG_DIGIT_LIMIT) begin
				digit_limit_q <= cfg_data[LIMIT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			quot_q     <= '0;
			frac_q     <= '0;
			int_cnt_q  <= '0;
			frac_cnt_q <= '0;
			keep_q     <= '0;
			emit_q     <= '0;
			bit_q      <= '0;
			is_frac_q  <= 1'b0;
			last_q     <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_take) begin
						quot_q     <= int_ext[INT_BITS-1:0];
						frac_q     <= frac_ext[FRAC_BITS-1:0];
						int_cnt_q  <= '0;
						frac_cnt_q <= '0;
						keep_q     <= '0;
						state_q    <= ST_INT_CHK;
					end
				end
				ST_INT_CHK: begin
					if (quot_q == '0) begin
						if (int_cnt_q == '0) begin
							int_cnt_q <= CNT_W'(1);
						end
						state_q <= ST_FRAC;
					end else begin
						bit_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					quot_q <= quot_nx;
					bit_q  <= bit_q + BW'(1);
					if (div_done) begin
						int_cnt_q <= int_cnt_q + CNT_W'(1);
						state_q   <= ST_INT_CHK;
					end
				end
				ST_FRAC: begin
					if (frac_done) begin
						emit_q  <= '0;
						state_q <= ST_EMIT_RD;
					end else begin
						frac_q     <= prod[FRAC_BITS-1:0];
						frac_cnt_q <= frac_cnt_q + CNT_W'(1);
						if (frac_digit != '0) begin
							keep_q <= frac_cnt_q + CNT_W'(1);
						end
					end
				end
				ST_EMIT_RD: begin
					is_frac_q <= (emit_q >= int_cnt_q);
					last_q    <= (emit_q + CNT_W'(1) == total);
					state_q   <= ST_EMIT_OUT;
				end
				ST_EMIT_OUT: begin
					if (digit_take) begin
						if (last_q) begin
							state_q <= ST_IDLE;
						end else begin
							emit_q  <= emit_q + CNT_W'(1);
							state_q <= ST_EMIT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_INT_CHK && quot_q != '0) begin
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q <= rem_nx[DIGIT_W-1:0];
		end
	end

	always_comb begin
		digit.digit_char     = digit_ascii(st_rdata);
		digit.is_fraction    = is_frac_q;
		digit.fraction_count = last_q ? keep_q : '0;
		digit.last           = last_q;
	end

endmodule
